// ===== src/epf_pkg.sv =====
// Package for the escaped packet framer.
// Holds the register map, the job record passed from front to back and queue sizing.
// No dependencies.
package epf_pkg;

  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned REG_START   = 0;
  localparam int unsigned REG_ESCAPE  = 1;
  localparam logic [7:0]  START_RST   = 8'd255;
  localparam logic [7:0]  ESCAPE_RST  = 8'd253;

  localparam int unsigned JOB_DEPTH   = 2;
  localparam int unsigned JOB_PTR_W   = $clog2(JOB_DEPTH);
  localparam int unsigned JOB_CNT_W   = $clog2(JOB_DEPTH + 1);

  // slot order: start, data prefix, data, checksum prefix, checksum
  localparam int unsigned SLOT_N      = 5;
  localparam int unsigned SLOT_START  = 0;
  localparam int unsigned SLOT_DPRE   = 1;
  localparam int unsigned SLOT_DATA   = 2;
  localparam int unsigned SLOT_SPRE   = 3;
  localparam int unsigned SLOT_SUM    = 4;

  typedef logic [SLOT_N-1:0] slot_mask_t;

  typedef struct packed {
    slot_mask_t mask;
    logic [7:0] start_b;
    logic [7:0] data_b;
    logic [7:0] sum_b;
  } job_t;

endpackage

// ===== src/epf_front.sv =====
// Front part of the escaped packet framer: configuration registers, checksum
// and classification of each accepted byte into a job record.
// Depends on epf_pkg.
module epf_front import epf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  output job_t              job,
  output logic [7:0]        esc_byte
);

  logic [7:0] start_r, start_nxt;
  logic [7:0] escape_r, escape_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] base;
  logic [7:0] new_sum;
  logic       data_esc;
  logic       sum_esc;
  logic       wr;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign esc_byte = escape_r;
  assign prdata   = {24'd0, (paddr[2] ? escape_r : start_r)};

  always_comb begin
    start_nxt  = start_r;
    escape_nxt = escape_r;
    if (wr) begin
      case (paddr[2])
        1'(REG_START):  start_nxt  = pwdata[7:0];
        1'(REG_ESCAPE): escape_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign base     = in_first_byte ? (8'd0 - start_r) : sum_r;
  assign new_sum  = base - in_data_byte;
  assign data_esc = (in_data_byte == start_r) || (in_data_byte == escape_r);
  assign sum_esc  = (new_sum == start_r) || (new_sum == escape_r);
  assign sum_nxt  = in_valid ? new_sum : sum_r;

  always_comb begin
    job.mask             = '0;
    job.mask[SLOT_START] = in_first_byte;
    job.mask[SLOT_DPRE]  = data_esc;
    job.mask[SLOT_DATA]  = 1'b1;
    job.mask[SLOT_SPRE]  = in_last_byte && sum_esc;
    job.mask[SLOT_SUM]   = in_last_byte;
    job.start_b          = start_r;
    job.data_b           = data_esc ? (in_data_byte - 8'd1) : in_data_byte;
    job.sum_b            = sum_esc ? (new_sum - 8'd1) : new_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= START_RST;
      escape_r <= ESCAPE_RST;
      sum_r    <= 8'd0;
    end else begin
      start_r  <= start_nxt;
      escape_r <= escape_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

// ===== src/epf_fifo.sv =====
// Short job queue between the front and back parts of the framer.
// Flip-flop storage, JOB_DEPTH entries. Depends on epf_pkg.
module epf_fifo import epf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic avail
);

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wp_r, wp_nxt;
  logic [JOB_PTR_W-1:0] rp_r, rp_nxt;
  logic [JOB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_wr;
  logic                 do_rd;

  assign full   = (cnt_r == JOB_CNT_W'(JOB_DEPTH));
  assign avail  = (cnt_r != '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && avail;
  assign rd_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/epf_back.sv =====
// Back part of the escaped packet framer: walks the slots of each job and emits
// one wire byte per cycle into the output register while it is free or popped. Depends on epf_pkg.
module epf_back import epf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] esc_byte,
  input  job_t       job_in,
  input  logic       job_avail,
  output logic       job_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_wire_byte,
  output logic       out_packet_end
);

  job_t       job_r, job_nxt;
  slot_mask_t mask_r, mask_nxt;
  slot_mask_t sel;
  slot_mask_t rest;
  logic       busy;
  logic       advance;
  logic       emit;
  logic       load;
  logic [7:0] byte_sel;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       oe_r, oe_nxt;

  assign busy    = (mask_r != '0);
  assign advance = !ov_r || pop;
  assign emit    = busy && advance;
  assign sel     = mask_r & (~mask_r + 1'b1);
  assign rest    = mask_r & ~sel;
  assign load    = job_avail && (!busy || (emit && (rest == '0)));
  assign job_pop = load;

  always_comb begin
    case (sel)
      slot_mask_t'(1 << SLOT_START): byte_sel = job_r.start_b;
      slot_mask_t'(1 << SLOT_DATA):  byte_sel = job_r.data_b;
      slot_mask_t'(1 << SLOT_SUM):   byte_sel = job_r.sum_b;
      default:                       byte_sel = esc_byte;
    endcase
  end

  always_comb begin
    mask_nxt = mask_r;
    job_nxt  = job_r;
    if (emit) begin
      mask_nxt = rest;
    end
    if (load) begin
      mask_nxt = job_in.mask;
      job_nxt  = job_in;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    oe_nxt = oe_r;
    if (emit) begin
      ov_nxt = 1'b1;
      ob_nxt = byte_sel;
      oe_nxt = sel[SLOT_SUM];
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  assign empty          = !ov_r;
  assign out_wire_byte  = ob_r;
  assign out_packet_end = oe_r;

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    ob_r  <= ob_nxt;
    oe_r  <= oe_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      ov_r   <= ov_nxt;
    end
  end

  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_avail)
    else $error("job taken from empty queue");

  a_load_data: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> mask_r[SLOT_DATA])
    else $error("loaded job lacks data slot");

  a_end_out: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && sel[SLOT_SUM]) |=> (ov_r && oe_r))
    else $error("checksum byte not marked as packet end");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !pop) |-> !emit)
    else $error("output register overwritten");

endmodule

// ===== src/escaped_packet_framer_core.sv =====
// Escaped packet framer, top level.
// Channels: packet bytes enter through push/full; each accepted transfer
// carries one raw byte with first/last flags. Wire bytes leave through
// empty/pop; the oldest result sits on out_* while empty is low.
// Registers start_byte (0x0) and escape_byte (0x4) sit on the APB port.
// A front stage classifies each byte and updates the checksum in the cycle
// it is accepted, and queues a job of one to five wire bytes. The back stage
// sends one wire byte per cycle, while the receiver keeps up, into a one-entry output register.
// With the block idle, the first wire byte of an item reaches the result ports
// through the job queue, the back stage's job register and the output register.
// Throughput: one wire byte per cycle out of the back stage while the receiver
// keeps up; an item makes one to five wire bytes, and input is taken every
// cycle while the 2-entry job queue has room.
// Reset (rst_n low, synchronous) clears the queue, the output register and
// the checksum and restores the register defaults 0xFF / 0xFD.
// If the receiver stalls, the output register holds, the back stage stops,
// the job queue fills, and full rises until pop resumes.
// Depends on epf_pkg, epf_front, epf_fifo, epf_back.
module escaped_packet_framer_core import epf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_wire_byte,
  output logic              out_packet_end
);

  job_t       fr_job;
  job_t       q_job;
  logic       q_avail;
  logic       q_pop;
  logic       acc;
  logic [7:0] esc_byte;

  assign acc = push && !full;

  epf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (acc),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .job           (fr_job),
    .esc_byte      (esc_byte)
  );

  epf_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_job (fr_job),
    .full   (full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .avail  (q_avail)
  );

  epf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .esc_byte       (esc_byte),
    .job_in         (q_job),
    .job_avail      (q_avail),
    .job_pop        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_wire_byte  (out_wire_byte),
    .out_packet_end (out_packet_end)
  );

endmodule

// ===== verif/tb_escaped_packet_framer_core.sv =====
// Testbench for escaped_packet_framer_core: packet bytes in, stuffed wire bytes out.
// A scoreboard class predicts start, escape and checksum bytes; config goes over APB.
// Depends on epf_pkg and the framer RTL.
`timescale 1ns / 1ps
module tb_escaped_packet_framer_core;
  import epf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       is_end;
  } wire_item_t;

  class wire_byte_scoreboard;
    logic [7:0] start_val;
    logic [7:0] escape_val;
    logic [7:0] sum_acc;
    wire_item_t due[$];
    int errors;

    function new();
      start_val = START_RST;
      escape_val = ESCAPE_RST;
      sum_acc = 8'd0;
      errors = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [7:0] v);
      if (idx == REG_START) start_val = v;
      else if (idx == REG_ESCAPE) escape_val = v;
    endfunction

    function void add_escaped(logic [7:0] b, logic fin);
      if (b == start_val || b == escape_val) begin
        due.push_back('{escape_val, 1'b0});
        b = b - 8'd1;
      end
      due.push_back('{b, fin});
    endfunction

    function void take_packet_byte(logic [7:0] d, logic f, logic l);
      if (f) begin
        due.push_back('{start_val, 1'b0});
        sum_acc = 8'd0 - start_val;
      end
      add_escaped(d, 1'b0);
      sum_acc = sum_acc - d;
      if (l) add_escaped(sum_acc, 1'b1);
    endfunction

    function void report(string msg);
      $display("tb mismatch: %s", msg);
      errors++;
    endfunction

    function void check_wire_byte(logic [7:0] b, logic e);
      wire_item_t exp_item;
      if (due.size() == 0) begin
        report($sformatf("unexpected wire byte %02h end %0b", b, e));
        return;
      end
      exp_item = due.pop_front();
      if (b !== exp_item.tx_byte)
        report($sformatf("wire_byte %02h, want %02h", b, exp_item.tx_byte));
      if (e !== exp_item.is_end)
        report($sformatf("packet_end %0b, want %0b (byte %02h)", e, exp_item.is_end, b));
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              push;
  logic              full;
  logic [7:0]        in_data_byte;
  logic              in_first_byte;
  logic              in_last_byte;
  logic              empty;
  logic              pop;
  logic [7:0]        out_wire_byte;
  logic              out_packet_end;

  wire_byte_scoreboard sb = new();
  bit tx_smooth;
  bit rx_smooth;
  bit rx_hold_req;
  int unsigned cycles = 0;

  escaped_packet_framer_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .empty         (empty),
    .pop           (pop),
    .out_wire_byte (out_wire_byte),
    .out_packet_end(out_packet_end)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_escaped_packet_framer_core: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_smooth) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bias toward values that hit the escape rule under the current registers
  function automatic logic [7:0] pick_data();
    logic [7:0] specials[8];
    specials = '{sb.start_val, sb.escape_val, sb.start_val - 8'd1, sb.start_val + 8'd1,
                 sb.escape_val - 8'd1, sb.escape_val + 8'd1, 8'h00, 8'hFF};
    if ($urandom_range(0, 99) < 35) return specials[$urandom_range(0, 7)];
    return 8'($urandom());
  endfunction

  task automatic put_byte(input logic [7:0] d, input logic f, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= d;
    in_first_byte <= f;
    in_last_byte <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.take_packet_byte(d, f, l);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [7:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic put_frame_bytes(input int n, input bit with_first, input bit with_last);
    for (int i = 0; i < n; i++)
      put_byte(pick_data(), with_first && i == 0, with_last && i == n - 1);
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int r;
    int n;
    bit drained;
    sent = 0;
    drained = 0;
    while (sent < n_items) begin
      tx_smooth = ($urandom_range(0, 9) == 0);
      rx_smooth = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        put_frame_bytes(n, 1'b1, 1'b1);
      end else if (r < 90) begin
        // broken packet: no last flag, next first abandons it
        n = $urandom_range(1, 4);
        put_frame_bytes(n, 1'b1, 1'b0);
      end else begin
        n = 1;
        put_byte(8'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      sent += n;
      if (!drained && sent >= n_items / 2 || $urandom_range(0, 99) < 3) begin
        wait_drained();
        drained = 1;
      end
    end
  endtask

  initial begin : rx_side
    int r;
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_wire_byte(out_wire_byte, out_packet_end);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (rx_smooth) begin
        pop <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          stall_left = $urandom_range(8, 40);
          pop <= 1'b0;
        end else begin
          pop <= (r >= 30);
        end
      end
    end
  end

  initial begin : tx_side
    logic [7:0] set_start[5];
    logic [7:0] set_escape[5];
    set_start = '{8'h00, 8'hFF, 8'h7E, 8'h00, 8'hFF};
    set_escape = '{8'hFF, 8'h00, 8'h7E, 8'h00, 8'hFD};
    rst_n = 1'b0;
    push = 1'b0;
    in_data_byte = 8'd0;
    in_first_byte = 1'b0;
    in_last_byte = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    tx_smooth = 1'b0;
    rx_smooth = 1'b0;
    rx_hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any packet opener run on the reset checksum
    put_byte(8'h10, 1'b0, 1'b0);
    put_byte(8'h20, 1'b0, 1'b1);
    // one-byte packets; 02 and 04 make the checksum hit start / escape
    put_byte(8'hFF, 1'b1, 1'b1);
    put_byte(8'hFD, 1'b1, 1'b1);
    put_byte(8'h02, 1'b1, 1'b1);
    put_byte(8'h04, 1'b1, 1'b1);
    put_byte(8'h00, 1'b1, 1'b1);
    // full packet with specials in the payload
    put_byte(8'h01, 1'b1, 1'b0);
    put_byte(8'h04, 1'b0, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'hFD, 1'b0, 1'b0);
    put_byte(8'hFE, 1'b0, 1'b0);
    put_byte(8'hFC, 1'b0, 1'b1);
    // new opener mid-packet
    put_byte(8'h05, 1'b1, 1'b0);
    put_byte(8'h03, 1'b0, 1'b0);
    put_byte(8'h07, 1'b1, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b1);
    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b1);
    run_random(60);

    for (int p = 0; p < 5; p++) begin
      if (p == 3) begin
        set_start[p] = 8'($urandom());
        set_escape[p] = 8'($urandom());
      end
      write_reg(REG_START, set_start[p]);
      write_reg(REG_ESCAPE, set_escape[p]);
      put_byte(8'h00, 1'b1, 1'b1);
      put_byte(sb.start_val, 1'b1, 1'b1);
      put_byte(sb.escape_val, 1'b1, 1'b1);
      // long receiver hold while the sender keeps offering bytes
      if (p == 1) rx_hold_req = 1'b1;
      run_random(65);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_escaped_packet_framer_core: done, clean");
    end else begin
      $display("tb_escaped_packet_framer_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/epf_pkg.sv
src/epf_front.sv
src/epf_fifo.sv
src/epf_back.sv
src/escaped_packet_framer_core.sv
verif/tb_escaped_packet_framer_core.sv
